### src/nfci_pkg.sv
// Shared types and constants for the NOR flash command interface.
// Command phase encoding, bus command codes, decoder result struct and the
// CFI query table. No dependencies.
`default_nettype none

package nfci_pkg;

  typedef enum logic [3:0] {
    PH_READ          = 4'd0,
    PH_UNLOCK1       = 4'd1,
    PH_UNLOCK2       = 4'd2,
    PH_PROGRAM       = 4'd3,
    PH_ERASE_SETUP   = 4'd4,
    PH_ERASE_UNLOCK1 = 4'd5,
    PH_ERASE_UNLOCK2 = 4'd6,
    PH_BYP_IDLE      = 4'd7,
    PH_BYP_PROGRAM   = 4'd8,
    PH_BYP_EXIT      = 4'd9
  } phase_t;

  localparam logic        MODE_READ  = 1'b0;

  localparam logic [15:0] ADDR_UNLOCK1 = 16'h0555;
  localparam logic [15:0] ADDR_UNLOCK2 = 16'h02AA;
  localparam logic [15:0] ADDR_QUERY   = 16'h0055;

  localparam logic [7:0]  CMD_UNLOCK1   = 8'hAA;
  localparam logic [7:0]  CMD_UNLOCK2   = 8'h55;
  localparam logic [7:0]  CMD_ERASE     = 8'h80;
  localparam logic [7:0]  CMD_SECTOR    = 8'h30;
  localparam logic [7:0]  CMD_PROGRAM   = 8'hA0;
  localparam logic [7:0]  CMD_BYPASS    = 8'h20;
  localparam logic [7:0]  CMD_BYP_RESET = 8'h90;
  localparam logic [7:0]  CMD_BYP_EXIT  = 8'h00;
  localparam logic [7:0]  CMD_QUERY     = 8'h98;
  localparam logic [7:0]  CMD_RESET     = 8'hF0;

  localparam logic [15:0] ERASED_WORD = 16'hFFFF;

  // outcome of one bus write, as seen by the command decoder
  typedef struct packed {
    phase_t phase_next;
    logic   bypass_next;
    logic   query_next;
    logic   err;
    logic   do_prog;
    logic   do_erase;
  } dec_t;

  function automatic logic [15:0] query_word(input logic [15:0] addr);
    logic [15:0] w;
    unique case (addr)
      16'h0010: w = 16'h0051;   // 'Q'
      16'h0011: w = 16'h0052;   // 'R'
      16'h0012: w = 16'h0059;   // 'Y'
      default:  w = 16'h0000;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### src/nfci_decode.sv
// Command sequence decoder for the NOR flash command interface.
// Pure combinational: maps the current phase and mode bits plus one bus
// write onto the next phase, mode bits and array action. Uses nfci_pkg.
`default_nettype none

module nfci_decode
  import nfci_pkg::*;
(
  input  phase_t      phase,
  input  logic        bypass_mode,
  input  logic        query_mode,
  input  logic [15:0] word_address,
  input  logic [7:0]  cmd,
  output dec_t        dec
);

  logic fail;
  logic at_unlock1;
  logic at_unlock2;

  assign at_unlock1 = (word_address == ADDR_UNLOCK1);
  assign at_unlock2 = (word_address == ADDR_UNLOCK2);

  always_comb begin
    dec.phase_next  = phase;
    dec.bypass_next = bypass_mode;
    dec.query_next  = query_mode;
    dec.err         = 1'b0;
    dec.do_prog     = 1'b0;
    dec.do_erase    = 1'b0;
    fail            = 1'b0;

    if (query_mode) begin
      // any write leaves query mode; only the reset command is clean
      dec.query_next = 1'b0;
      dec.phase_next = PH_READ;
      dec.err        = (cmd != CMD_RESET);
    end else begin
      unique case (phase)
        PH_PROGRAM: begin
          dec.do_prog    = 1'b1;
          dec.phase_next = PH_READ;
        end
        PH_BYP_PROGRAM: begin
          dec.do_prog    = 1'b1;
          dec.phase_next = PH_BYP_IDLE;
        end
        PH_BYP_IDLE: begin
          if (cmd == CMD_PROGRAM) dec.phase_next = PH_BYP_PROGRAM;
          else if (cmd == CMD_BYP_RESET) dec.phase_next = PH_BYP_EXIT;
          else fail = 1'b1;
        end
        PH_BYP_EXIT: begin
          if (cmd == CMD_BYP_EXIT) begin
            dec.bypass_next = 1'b0;
            dec.phase_next  = PH_READ;
          end else begin
            fail = 1'b1;
          end
        end
        default: begin
          if (cmd == CMD_RESET) begin
            dec.phase_next = PH_READ;
          end else if (phase == PH_READ) begin
            if (at_unlock1 && cmd == CMD_UNLOCK1) dec.phase_next = PH_UNLOCK1;
            else if (word_address == ADDR_QUERY && cmd == CMD_QUERY) dec.query_next = 1'b1;
            else fail = 1'b1;
          end else if (phase == PH_UNLOCK1) begin
            // a repeated first unlock cycle here counts as broken
            if (at_unlock2 && cmd == CMD_UNLOCK2) dec.phase_next = PH_UNLOCK2;
            else fail = 1'b1;
          end else if (phase == PH_ERASE_SETUP) begin
            if (at_unlock1 && cmd == CMD_UNLOCK1) dec.phase_next = PH_ERASE_UNLOCK1;
            else fail = 1'b1;
          end else if (phase == PH_UNLOCK2) begin
            if (at_unlock1 && cmd == CMD_PROGRAM) begin
              dec.phase_next = PH_PROGRAM;
            end else if (at_unlock1 && cmd == CMD_ERASE) begin
              dec.phase_next = PH_ERASE_SETUP;
            end else if (at_unlock1 && cmd == CMD_BYPASS) begin
              dec.bypass_next = 1'b1;
              dec.phase_next  = PH_BYP_IDLE;
            end else begin
              fail = 1'b1;
            end
          end else if (phase == PH_ERASE_UNLOCK1) begin
            if (at_unlock2 && cmd == CMD_UNLOCK2) dec.phase_next = PH_ERASE_UNLOCK2;
            else fail = 1'b1;
          end else if (phase == PH_ERASE_UNLOCK2) begin
            if (cmd == CMD_SECTOR) begin
              dec.do_erase   = 1'b1;
              dec.phase_next = PH_READ;
            end else begin
              fail = 1'b1;
            end
          end else begin
            fail = 1'b1;
          end
        end
      endcase

      if (fail) begin
        dec.phase_next  = PH_READ;
        dec.bypass_next = 1'b0;
        dec.query_next  = 1'b0;
        dec.err         = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/nor_flash_command_interface.sv
// NOR flash command interface: top level with array memory and sequencer.
// Depends on nfci_pkg and nfci_decode.
//
// A 16-bit NOR flash device with the standard unlock command set, driven one
// bus request at a time over a valid/ready channel, each request giving one
// result. After reset the array is swept to all ones with in_ready low.
// Command writes and query-mode reads go from accept to S_DONE, where the
// output register loads once it is free, and then back to S_IDLE for the next
// request. Array reads and program writes pass S_QUOT and S_PROD, where one
// shared multiplier first forms the quotient of the address by ARRAY_WORDS
// from a reciprocal constant, then multiplies it back so that subtracting it
// from the address gives the word index; then S_MEMRD and S_MEMUSE read the
// memory (and write it back for a program). A sector erase uses the same
// multiplier steps, S_QUOT and S_PROD, to find the sector base, then writes one
// word a cycle for up to SECTOR_WORDS words (fewer at the top of the array).
// The result sits in an output register, so the next request is taken while it waits.
`default_nettype none

module nor_flash_command_interface
  import nfci_pkg::*;
#(
  parameter int ARRAY_WORDS  = 65536,
  parameter int SECTOR_WORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        mode,
  input  wire logic [15:0] word_address,
  input  wire logic [15:0] write_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      read_data,
  output logic             bypass_active,
  output logic             query_active,
  output logic             sequence_error
);

  localparam int IW  = $clog2(ARRAY_WORDS);
  localparam int SKW = $clog2(SECTOR_WORDS);
  localparam int EAW = ((IW + 1) > 17) ? (IW + 1) : 17;
  localparam int MW  = 18;
  localparam int PW  = 16 + MW;

  // quotient = (addr * ceil(2^SH / D)) >> SH, exact for any 16-bit address
  localparam int          ARR_SH  = 16 + IW;
  localparam int          SEC_SH  = 16 + SKW;
  localparam logic [63:0] ARR_RCP = ((64'd1 << ARR_SH) + 64'(ARRAY_WORDS) - 64'd1) /
                                    64'(ARRAY_WORDS);
  localparam logic [63:0] SEC_RCP = ((64'd1 << SEC_SH) + 64'(SECTOR_WORDS) - 64'd1) /
                                    64'(SECTOR_WORDS);

  localparam logic [MW-1:0]  ARR_M    = MW'(ARR_RCP);
  localparam logic [MW-1:0]  SEC_M    = MW'(SEC_RCP);
  // q*D never exceeds the address, so the low 16 bits of D are enough
  localparam logic [MW-1:0]  ARR_DM   = MW'(16'(ARRAY_WORDS));
  localparam logic [MW-1:0]  SEC_DM   = MW'(16'(SECTOR_WORDS));
  localparam logic [IW-1:0]  CLR_LAST = IW'(ARRAY_WORDS - 1);
  localparam logic [SKW-1:0] ERS_LAST = SKW'(SECTOR_WORDS - 1);
  localparam logic [EAW-1:0] ARR_END  = EAW'(ARRAY_WORDS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_QUOT,
    S_PROD,
    S_MEMRD,
    S_MEMUSE,
    S_ERASE,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    OP_READ,
    OP_PROG,
    OP_ERASE
  } op_t;

  state_t        state;
  op_t           op;
  phase_t        phase;
  logic          bypass_mode;
  logic          query_mode;
  logic [IW-1:0] clr_idx;
  logic [15:0]   addr_q;
  logic [15:0]   data_q;
  logic [15:0]   res_data;
  logic          res_err;

  logic          div_sector;
  logic [15:0]   quot;
  logic [15:0]   mul_x;
  logic [MW-1:0] mul_y;
  logic [PW-1:0] prod;

  logic [15:0]    base_q;
  logic [SKW-1:0] ers_k;
  logic [EAW-1:0] ers_a;
  logic           ers_in;
  logic           ers_last;

  logic [IW-1:0] idx_q;
  logic [15:0]   mem_q;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic [15:0]   mem [ARRAY_WORDS];

  dec_t dec;

  nfci_decode u_decode (
    .phase        (phase),
    .bypass_mode  (bypass_mode),
    .query_mode   (query_mode),
    .word_address (word_address),
    .cmd          (write_data[7:0]),
    .dec          (dec)
  );

  assign in_ready = (state == S_IDLE);

  // shared multiplier: address by reciprocal, then quotient by divisor
  assign mul_x = (state == S_PROD) ? quot : addr_q;
  assign mul_y = (state == S_PROD) ? (div_sector ? SEC_DM : ARR_DM)
                                   : (div_sector ? SEC_M : ARR_M);
  assign prod  = PW'(mul_x) * PW'(mul_y);

  // erase sweep stops at the sector end or at the top of the array
  assign ers_a    = EAW'(base_q) + EAW'(ers_k);
  assign ers_in   = (ers_a < ARR_END);
  assign ers_last = (ers_k == ERS_LAST) || !ers_in;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q;
    mem_wd = mem_q & data_q;
    priority if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_idx;
      mem_wd = ERASED_WORD;
    end else if (state == S_ERASE && ers_in) begin
      mem_we = 1'b1;
      mem_wa = IW'(ers_a);
      mem_wd = ERASED_WORD;
    end else if (state == S_MEMUSE && op == OP_PROG) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[idx_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      phase       <= PH_READ;
      bypass_mode <= 1'b0;
      query_mode  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // in S_DONE the output register is reloaded on a taken result
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == CLR_LAST) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            addr_q <= word_address;
            data_q <= write_data;
            if (mode == MODE_READ) begin
              res_err <= 1'b0;
              if (query_mode) begin
                res_data <= query_word(word_address);
                state    <= S_DONE;
              end else begin
                op         <= OP_READ;
                div_sector <= 1'b0;
                state      <= S_QUOT;
              end
            end else begin
              res_data    <= '0;
              phase       <= dec.phase_next;
              bypass_mode <= dec.bypass_next;
              query_mode  <= dec.query_next;
              res_err     <= dec.err;
              if (dec.do_prog) begin
                op         <= OP_PROG;
                div_sector <= 1'b0;
                state      <= S_QUOT;
              end else if (dec.do_erase) begin
                op         <= OP_ERASE;
                div_sector <= 1'b1;
                state      <= S_QUOT;
              end else begin
                state <= S_DONE;
              end
            end
          end
        end

        S_QUOT: begin
          quot  <= div_sector ? 16'(prod >> SEC_SH) : 16'(prod >> ARR_SH);
          state <= S_PROD;
        end

        S_PROD: begin
          if (op == OP_ERASE) begin
            base_q <= prod[15:0];
            ers_k  <= '0;
            state  <= S_ERASE;
          end else begin
            idx_q <= IW'(addr_q - prod[15:0]);
            state <= S_MEMRD;
          end
        end

        S_MEMRD: begin
          state <= S_MEMUSE;
        end

        S_MEMUSE: begin
          if (op == OP_READ) begin
            res_data <= mem_q;
          end
          state <= S_DONE;
        end

        S_ERASE: begin
          ers_k <= ers_k + 1'b1;
          if (ers_last) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            read_data      <= res_data;
            bypass_active  <= bypass_mode;
            query_active   <= query_mode;
            sequence_error <= res_err;
            state          <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_bypass_phase: assert property (@(posedge clk) disable iff (rst)
    bypass_mode |-> (phase == PH_BYP_IDLE || phase == PH_BYP_PROGRAM || phase == PH_BYP_EXIT))
    else $error("bypass mode outside bypass phases");

  a_query_phase: assert property (@(posedge clk) disable iff (rst)
    query_mode |-> (phase == PH_READ && !bypass_mode))
    else $error("query mode with a pending command sequence");

  a_err_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sequence_error) |-> (!bypass_active && !query_active))
    else $error("broken sequence left a mode active");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !in_ready)
    else $error("array written while taking requests");
`endif

endmodule

`default_nettype wire
